/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the top level of the sorted time list.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: lhs implies rhs");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: lhs implies rhs next cycle");

`endif

/* rtl/stil_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stil_pkg
// Types, widths and codes shared by the sorted time list modules.
// ---------------------------------------------------------------------------
package stil_pkg;

   // Number of cells in the list.
   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Fixed port widths.
   localparam int HOURS_W   = 5;
   localparam int MINUTES_W = 6;
   localparam int RDIDX_W   = 4;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 5;
   localparam int COUNT_W   = 5;

   // Command codes.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd2;

   // A stored time; hours sit above minutes so the packed word orders correctly.
   typedef struct packed {
      logic [HOURS_W-1:0]   hours;
      logic [MINUTES_W-1:0] minutes;
   } time_type;

   // What one cell hands to its right-hand neighbor.
   typedef struct packed {
      logic     shift;
      time_type word;
   } link_type;

endpackage

/* rtl/sorted_time_insert_list.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_time_insert_list
// Sorted list of hh:mm times built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Ports
// request   in         start high, busy low    req_command, req_new_hours,
//                                              req_new_minutes, req_read_index
// response  out        rsp_valid strobe        rsp_status, rsp_slot,
//                                              rsp_held_count, rsp_out_hours,
//                                              rsp_out_minutes
//
// On an insert that finds room, all cells compare and shift at the edge that
// takes the command; the response shows in the cycle after, for one cycle. A
// command can be given in every cycle in which busy is low. busy is set while
// reset is high and cleared at any edge at which reset is low. Reset empties
// the list; the cell contents are not cleared. The response cannot be stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_time_insert_list
   import stil_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_command,
   input  logic [HOURS_W-1:0]   req_new_hours,
   input  logic [MINUTES_W-1:0] req_new_minutes,
   input  logic [RDIDX_W-1:0]   req_read_index,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [COUNT_W-1:0]   rsp_held_count,
   output logic [HOURS_W-1:0]   rsp_out_hours,
   output logic [MINUTES_W-1:0] rsp_out_minutes
);

   logic                 busy_ff;
   logic                 valid_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [HOURS_W-1:0]   hours_ff, hours_in;
   logic [MINUTES_W-1:0] minutes_ff, minutes_in;

   logic       accept;
   logic       full;
   logic       insert_en;
   logic       idx_held;
   time_type   key;
   time_type   read_word;
   logic [CNT_W-1:0] chain_slot;

   assign accept    = start && !busy_ff;
   assign full      = (32'(count_ff) >= LIST_DEPTH);
   assign insert_en = accept && (req_command == CMD_INSERT) && !full;
   assign key       = '{hours: req_new_hours, minutes: req_new_minutes};
   assign idx_held  = (32'(req_read_index) < 32'(count_ff)) &&
                      (32'(req_read_index) < LIST_DEPTH);

   stil_chain u_chain (
      .clock     (clock),
      .insert_en (insert_en),
      .key       (key),
      .count     (count_ff),
      .read_idx  (IDX_W'(req_read_index)),
      .slot      (chain_slot),
      .read_word (read_word)
   );

   // Response fields for the command being transferred.
   always_comb begin
      count_in   = count_ff;
      status_in  = STATUS_OK;
      slot_in    = '0;
      hours_in   = '0;
      minutes_in = '0;
      if (req_command == CMD_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            slot_in  = SLOT_W'(chain_slot);
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (idx_held) begin
            hours_in   = read_word.hours;
            minutes_in = read_word.minutes;
         end else begin
            status_in = STATUS_NOT_HELD;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_held_count  = COUNT_W'(count_ff);
   assign rsp_out_hours   = hours_ff;
   assign rsp_out_minutes = minutes_ff;

   // Checks on the count and the response timing.
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, (32'(count_ff) <= LIST_DEPTH))
   `ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid)
   `ASSERT_IMPLIES(a_full_count, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), (32'(count_ff) == LIST_DEPTH))
   `ASSERT_NEXT(a_insert_grows, clock, reset, insert_en, (count_ff == $past(count_ff) + CNT_W'(1)))
   `ASSERT_IMPLIES(a_slot_in_range, clock, reset, rsp_valid && (rsp_status == STATUS_OK), (32'(rsp_slot) < 32'(count_ff)) || (rsp_slot == '0))

endmodule

/* rtl/stil_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stil_cell
// One list position: holds a time, compares it with the new key and either
// keeps it, takes the left neighbor's time or takes the key on an insert.
// ---------------------------------------------------------------------------
module stil_cell
   import stil_pkg::*;
(
   input  logic     clock,
   input  logic     insert_en,
   input  time_type key,
   input  logic     occupied,
   input  logic     at_tail,
   input  link_type left_link,
   output link_type right_link,
   output logic     takes_key,
   output time_type word
);

   time_type entry_ff;
   time_type entry_in;
   logic     later;

   // An occupied entry later than the key moves up one place.
   assign later      = occupied && (entry_ff > key);
   assign right_link = '{shift: later, word: entry_ff};
   assign takes_key  = !left_link.shift && (later || at_tail);
   assign word       = entry_ff;

   // Next value: left neighbor's time, the key, or the current time.
   always_comb begin
      entry_in = entry_ff;
      if (insert_en) begin
         if (left_link.shift) begin
            entry_in = left_link.word;
         end else if (later || at_tail) begin
            entry_in = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/stil_chain.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stil_chain
// Row of list cells with the slot encoder for inserts and the read select.
// ---------------------------------------------------------------------------
module stil_chain
   import stil_pkg::*;
(
   input  logic             clock,
   input  logic             insert_en,
   input  time_type         key,
   input  logic [CNT_W-1:0] count,
   input  logic [IDX_W-1:0] read_idx,
   output logic [CNT_W-1:0] slot,
   output time_type         read_word
);

   link_type links [LIST_DEPTH+1];
   logic     takes [LIST_DEPTH];
   time_type words [LIST_DEPTH];

   // Cell zero has no left neighbor to take from.
   assign links[0] = '{shift: 1'b0, word: '0};

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      stil_cell u_cell (
         .clock      (clock),
         .insert_en  (insert_en),
         .key        (key),
         .occupied   (CNT_W'(i) < count),
         .at_tail    (CNT_W'(i) == count),
         .left_link  (links[i]),
         .right_link (links[i+1]),
         .takes_key  (takes[i]),
         .word       (words[i])
      );
   end

   // Exactly one cell takes the key when the list has room; encode its place.
   always_comb begin
      slot = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (takes[i]) begin
            slot = slot | CNT_W'(i);
         end
      end
   end

   // The last cell's outgoing link has no neighbor; the entry held there is
   // only ever dropped by the full check in the top level.
   logic unused_tail;
   assign unused_tail = links[LIST_DEPTH].shift;

   assign read_word = words[read_idx];

endmodule
